// File: src/timer_queue_scheduler_core_defines.svh
// ----------------------------------------------------------------------------
// Timer queue scheduler assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMER_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define TIMER_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TQS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("tqs check failed");
`define TQS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("tqs check failed");
`else
`define TQS_ASSERT_NOW(lbl, ante, cons)
`define TQS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/tqs_pkg.sv
// ----------------------------------------------------------------------------
// Timer queue scheduler package
// Beat types, request and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tqs_pkg;

	localparam int TIME_BITS = 48;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BADID = 2'd2;

	localparam logic [19:0] MIN_DELAY_RST = 20'd1000;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [3:0]           timer_id;
		logic [TIME_BITS-1:0] expiry_time;
		logic [TIME_BITS-1:0] repeat_interval;
		logic [TIME_BITS-1:0] now_time;
	} tqs_req_t;

	typedef struct packed {
		logic [3:0]           result_id;
		logic                 fired;
		logic                 rearm;
		logic [TIME_BITS-1:0] rearm_delay;
		logic [1:0]           status;
		logic                 last;
	} tqs_rsp_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic fire;
		logic finish;
	} tqs_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       full;
		logic       scan_done;
		logic       best_vld;
		logic       hold_vld;
		logic       out_free;
	} tqs_sts_t;

endpackage
`default_nettype wire

// File: src/tqs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tqs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire                                    clk,
	input  wire                                    we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                        wdata,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: src/tqs_ctrl.sv
// ----------------------------------------------------------------------------
// Timer queue scheduler controller
// Sequences request decode, slot scans, timer firing and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tqs_ctrl import tqs_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_stall,
	input  tqs_sts_t  sts,
	output tqs_cmd_t  cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_SCAN  = 6'b000100,
		S_FRD   = 6'b001000,
		S_FWR   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				unique case (sts.req_type)
					REQ_ADD: begin
						if (sts.full) begin
							state_d = S_FIN;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					REQ_CANCEL: state_d = S_FIN;
					REQ_TICK: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = (sts.req_type == REQ_TICK && sts.best_vld) ? S_FRD : S_FIN;
				end
			end
			S_FRD: state_d = S_FWR;
			S_FWR: begin
				if (!sts.hold_vld || sts.out_free) begin
					cmd.fire       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
endmodule
`default_nettype wire

// File: src/tqs_dp.sv
// ----------------------------------------------------------------------------
// Timer queue scheduler datapath
// Slot tables, scan comparators, rearm delay unit and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tqs_dp import tqs_pkg::*; #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  tqs_req_t    in_data,
	input  wire  [19:0] min_delay,
	input  tqs_cmd_t    cmd,
	output tqs_sts_t    sts,
	output logic        out_valid,
	input  wire         out_stall,
	output tqs_rsp_t    out_data
);
	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

	tqs_req_t               req_q;
	logic [TIMER_SLOTS-1:0] active_q;
	logic                   scan_on_q, vld_s1, done_q;
	logic [IDX_W-1:0]       scan_idx_q, idx_s1;
	logic                   best_vld_q, live_vld_q, hold_vld_q;
	logic [IDX_W-1:0]       best_idx_q, hold_id_q;
	logic [TIME_BITS-1:0]   best_exp_q, live_exp_q;
	logic                   out_vld_q;
	tqs_rsp_t               out_q;

	logic [TIME_BITS-1:0] now_t, exp_t, ivl_t, rd_exp, rd_ivl;
	logic [TIME_BITS:0]   restart_sum;
	logic [TIME_BITS-1:0] restart_t, dly_arg, dly_diff, dly, min_t;
	logic [IDX_W-1:0]     free_idx;
	logic                 full, out_free, id_ok, add_rearm, add_ok, act_s1;
	logic                 exp_we;
	logic [IDX_W-1:0]     exp_waddr;
	logic [TIME_BITS-1:0] exp_wdata;
	tqs_rsp_t             fin_rsp, hold_rsp;

	assign now_t = TIME_BITS'(req_q.now_time);
	assign exp_t = TIME_BITS'(req_q.expiry_time);
	assign ivl_t = TIME_BITS'(req_q.repeat_interval);
	assign min_t = TIME_BITS'(min_delay);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
	end

	always_comb begin
		free_idx = '0;
		full     = 1'b1;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = IDX_W'(i);
				full     = 1'b0;
			end
		end
	end

	assign add_ok = cmd.finish && req_q.req_type == REQ_ADD && !full;
	assign id_ok  = (32'(req_q.timer_id) < TIMER_SLOTS) &&
		active_q[IDX_W'(req_q.timer_id)];

	// scan sweep: address issue, then compare on the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_on_q  <= 1'b0;
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_on_q  <= 1'b1;
				scan_idx_q <= '0;
			end else if (scan_on_q) begin
				if (scan_idx_q == LAST_IDX) begin
					scan_on_q <= 1'b0;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			vld_s1 <= scan_on_q;
			done_q <= vld_s1 && idx_s1 == LAST_IDX;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
	end

	assign act_s1 = active_q[idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
			live_vld_q <= 1'b0;
		end else if (cmd.scan_start) begin
			best_vld_q <= 1'b0;
			live_vld_q <= 1'b0;
		end else if (vld_s1 && act_s1) begin
			if (!live_vld_q || rd_exp < live_exp_q) begin
				live_vld_q <= 1'b1;
			end
			if (rd_exp < now_t && (!best_vld_q || rd_exp < best_exp_q)) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && act_s1 && !cmd.scan_start) begin
			if (!live_vld_q || rd_exp < live_exp_q) begin
				live_exp_q <= rd_exp;
			end
			if (rd_exp < now_t && (!best_vld_q || rd_exp < best_exp_q)) begin
				best_exp_q <= rd_exp;
				best_idx_q <= idx_s1;
			end
		end
	end

	// restart at now + interval, saturating
	assign restart_sum = {1'b0, now_t} + {1'b0, rd_ivl};
	assign restart_t   = restart_sum[TIME_BITS] ? '1 : restart_sum[TIME_BITS-1:0];

	assign exp_we    = add_ok || (cmd.fire && rd_ivl != '0);
	assign exp_waddr = cmd.fire ? best_idx_q : free_idx;
	assign exp_wdata = cmd.fire ? restart_t : exp_t;

	tqs_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMER_SLOTS)) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (exp_waddr),
		.wdata (exp_wdata),
		.raddr (scan_idx_q),
		.rdata (rd_exp)
	);

	tqs_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMER_SLOTS)) u_ivl_ram (
		.clk   (clk),
		.we    (add_ok),
		.waddr (free_idx),
		.wdata (ivl_t),
		.raddr (best_idx_q),
		.rdata (rd_ivl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else begin
			if (add_ok) begin
				active_q[free_idx] <= 1'b1;
			end
			if (cmd.finish && req_q.req_type == REQ_CANCEL && id_ok) begin
				active_q[IDX_W'(req_q.timer_id)] <= 1'b0;
			end
			if (cmd.fire && rd_ivl == '0) begin
				active_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// fired slot held back until it is known whether it closes the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
		end else if (cmd.fire) begin
			hold_vld_q <= 1'b1;
		end else if (cmd.finish) begin
			hold_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			hold_id_q <= best_idx_q;
		end
	end

	// rearm delay: max(expiry - now, min), min when already due
	assign dly_arg   = (req_q.req_type == REQ_ADD) ? exp_t : live_exp_q;
	assign dly_diff  = dly_arg - now_t;
	assign dly       = (dly_arg <= now_t || dly_diff < min_t) ? min_t : dly_diff;
	assign add_rearm = !live_vld_q || exp_t < live_exp_q;

	always_comb begin
		fin_rsp      = '0;
		fin_rsp.last = 1'b1;
		unique case (req_q.req_type)
			REQ_ADD: begin
				if (full) begin
					fin_rsp.status = ST_FULL;
				end else begin
					fin_rsp.result_id   = 4'(free_idx);
					fin_rsp.rearm       = add_rearm;
					fin_rsp.rearm_delay = add_rearm ? dly : '0;
				end
			end
			REQ_CANCEL: begin
				fin_rsp.result_id = req_q.timer_id;
				fin_rsp.status    = id_ok ? ST_OK : ST_BADID;
			end
			default: begin
				fin_rsp.result_id   = hold_vld_q ? 4'(hold_id_q) : 4'd0;
				fin_rsp.fired       = hold_vld_q;
				fin_rsp.rearm       = live_vld_q;
				fin_rsp.rearm_delay = live_vld_q ? dly : '0;
			end
		endcase
	end

	always_comb begin
		hold_rsp           = '0;
		hold_rsp.result_id = 4'(hold_id_q);
		hold_rsp.fired     = 1'b1;
	end

	assign out_free = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish || (cmd.fire && hold_vld_q)) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= fin_rsp;
		end else if (cmd.fire && hold_vld_q) begin
			out_q <= hold_rsp;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	assign sts.req_type  = req_q.req_type;
	assign sts.full      = full;
	assign sts.scan_done = done_q;
	assign sts.best_vld  = best_vld_q;
	assign sts.hold_vld  = hold_vld_q;
	assign sts.out_free  = out_free;
endmodule
`default_nettype wire

// File: src/timer_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// Timer queue scheduler core
// Table of software timers: add, cancel and tick with ordered expiry beats.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// in       | in_valid / in_stall   | in_data  (tqs_req_t)
// out      | out_valid / out_stall | out_data (tqs_rsp_t)
// cfg      | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// One request at a time. Cancel makes no sweep. Add makes one sweep of the
// expiry RAM for the earliest live timer (none when the table is full).
// Tick makes one expiry RAM sweep per fired timer plus a closing sweep.
// No clearing pass after reset: live bits are flops. Out stalls hold the
// sequencer only when a new beat must be written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "timer_queue_scheduler_core_defines.svh"
module timer_queue_scheduler_core import tqs_pkg::*; #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  tqs_req_t    in_data,
	output logic        out_valid,
	input  wire         out_stall,
	output tqs_rsp_t    out_data,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	tqs_cmd_t    cmd;
	tqs_sts_t    sts;
	logic [19:0] min_delay_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= MIN_DELAY_RST;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			min_delay_q <= pwdata[19:0];
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? {12'd0, min_delay_q} : 32'd0;

	tqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tqs_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.min_delay (min_delay_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`TQS_ASSERT_NOW(a_fired_ok, out_valid && out_data.fired, out_data.status == ST_OK)
	`TQS_ASSERT_NOW(a_no_rearm_zero, out_valid && !out_data.rearm, out_data.rearm_delay == '0)
	`TQS_ASSERT_NOW(a_full_form, out_valid && out_data.status == ST_FULL, out_data.last)
	`TQS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
endmodule
`default_nettype wire
